>>> hw/rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 decoder with replacement.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned BUF_D  = 4;   // held bytes plus the new byte
    localparam int unsigned IDX_W  = 3;   // holds 0..BUF_D
    localparam int unsigned CNT_W  = 2;   // held count 0..3

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;

    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] CODE_LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] CODE_LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] CODE_LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_CONT  = 8'h80;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // Outcome of decoding the form that starts at the scan position
    typedef struct packed {
        logic             incomplete; // form cut short and text not ended
        logic [CP_W-1:0]  cp;         // result to give when not incomplete
        logic [IDX_W-1:0] adv;        // bytes consumed
    } t_form;

endpackage

>>> hw/rtl/utf8d_if.sv
// ----------------------------------------------------------------------------
// utf8d_if
// Valid/ready channels for raw text bytes and decoded code points.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] input_byte;
    logic       end_of_text;

    modport source (output valid, output input_byte, output end_of_text, input ready);
    modport sink   (input valid, input input_byte, input end_of_text, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

>>> hw/rtl/utf8_decoder_with_replacement.sv
// Flow: a byte is taken while idle, then the scan steps through the held bytes form
//   by form and then closes, each step stalled while the output beat waits.
// A new byte is taken only after the scan for the last byte has closed; the pace is
//   set by the single form decoder that the sequencer steps along the held bytes.
// Reset: synchronous, active low; clears the held count, state and valid flags.
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// UTF-8 to code point decoder; bad or cut forms give U+FFFD.
// ----------------------------------------------------------------------------
module utf8_decoder_with_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_in_if.sink    i_in,
    utf8d_out_if.source o_out
);
    import utf8d_pkg::*;

    t_state                  r_state, n_state;
    logic [BUF_D-1:0][7:0]   r_buf, n_buf;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_n, n_n;
    logic [IDX_W-1:0]        r_i, n_i;
    logic                    r_eot, n_eot;
    logic                    r_pend_v, n_pend_v;
    logic [CP_W-1:0]         r_pend_cp, n_pend_cp;
    logic                    r_out_v, n_out_v;
    logic [CP_W-1:0]         r_out_cp, n_out_cp;
    logic                    r_out_last, n_out_last;

    logic [3:0][7:0]         window;
    logic [IDX_W-1:0]        avail;
    t_form                   form;
    logic                    out_free;
    logic                    done;
    logic                    go;

    // gather the bytes from the scan position on
    always_comb begin
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < BUF_D; k++) begin
            idx       = r_i + IDX_W'(k);
            window[k] = (idx < IDX_W'(BUF_D)) ? r_buf[idx[1:0]] : 8'h00;
        end
    end

    assign avail = r_n - r_i;

    utf8d_form_unit u_form (
        .i_window (window),
        .i_avail  (avail),
        .i_eot    (r_eot),
        .o_form   (form)
    );

    assign out_free = !r_out_v || o_out.ready;
    assign done     = (r_i >= r_n) || form.incomplete;
    assign go       = !r_pend_v || out_free;

    // sequencer: accept a byte, then walk the forms one per cycle unless the output stalls
    always_comb begin
        n_state    = r_state;
        n_buf      = r_buf;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_i        = r_i;
        n_eot      = r_eot;
        n_pend_v   = r_pend_v;
        n_pend_cp  = r_pend_cp;
        n_out_v    = r_out_v && !o_out.ready;
        n_out_cp   = r_out_cp;
        n_out_last = r_out_last;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_buf[r_cnt] = i_in.input_byte;
                    n_n          = {1'b0, r_cnt} + 3'd1;
                    n_i          = '0;
                    n_eot        = i_in.end_of_text;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (go) begin
                    // push the held result; it is last only when the scan ends
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_cp   = r_pend_cp;
                        n_out_last = done;
                    end
                    if (done) begin
                        n_pend_v = 1'b0;
                        for (int k = 0; k < BUF_D - 1; k++) begin
                            n_buf[k] = window[k];
                        end
                        n_cnt   = (r_eot || (r_i >= r_n)) ? '0 : avail[CNT_W-1:0];
                        n_state = ST_IDLE;
                    end else begin
                        n_pend_v  = 1'b1;
                        n_pend_cp = form.cp;
                        n_i       = r_i + form.adv;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_n        <= n_n;
        r_i        <= n_i;
        r_eot      <= n_eot;
        r_pend_cp  <= n_pend_cp;
        r_out_cp   <= n_out_cp;
        r_out_last <= n_out_last;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_v;
    assign o_out.code_point  = r_out_cp;
    assign o_out.last_of_run = r_out_last;

endmodule

>>> hw/rtl/utf8d_form_unit.sv
// ----------------------------------------------------------------------------
// utf8d_form_unit
// Decodes one UTF-8 form from a byte window; reused once per scan step.
// ----------------------------------------------------------------------------
module utf8d_form_unit (
    input  logic [3:0][7:0]      i_window, // window[0] is the scan position
    input  logic [2:0]           i_avail,  // bytes available from the scan position
    input  logic                 i_eot,
    output utf8d_pkg::t_form     o_form
);
    import utf8d_pkg::*;

    logic [BYTE_W-1:0] b0;
    logic              lead2, lead3, lead4;
    logic [IDX_W-1:0]  len;
    logic              cont1, cont2, cont3;
    logic              cont_ok;
    logic [CP_W-1:0]   cp2, cp3, cp4, cp;
    logic              overlong, surrogate, too_big;

    assign b0    = i_window[0];
    assign lead2 = (b0 & MASK_LEAD2) == CODE_LEAD2;
    assign lead3 = (b0 & MASK_LEAD3) == CODE_LEAD3;
    assign lead4 = (b0 & MASK_LEAD4) == CODE_LEAD4;
    assign len   = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);

    assign cont1 = (i_window[1] & MASK_CONT) == CODE_CONT;
    assign cont2 = (i_window[2] & MASK_CONT) == CODE_CONT;
    assign cont3 = (i_window[3] & MASK_CONT) == CODE_CONT;

    // assemble the payload bits of each form length
    assign cp2 = {10'd0, b0[4:0], i_window[1][5:0]};
    assign cp3 = {5'd0, b0[3:0], i_window[1][5:0], i_window[2][5:0]};
    assign cp4 = {b0[2:0], i_window[1][5:0], i_window[2][5:0], i_window[3][5:0]};

    always_comb begin
        cont_ok  = 1'b0;
        cp       = cp4;
        overlong = 1'b0;
        too_big  = 1'b0;
        if (lead2) begin
            cont_ok  = cont1;
            cp       = cp2;
            overlong = cp2 < CP_MIN_2;
        end else if (lead3) begin
            cont_ok  = cont1 && cont2;
            cp       = cp3;
            overlong = cp3 < CP_MIN_3;
        end else begin
            cont_ok  = cont1 && cont2 && cont3;
            cp       = cp4;
            overlong = cp4 < CP_MIN_4;
            too_big  = cp4 > CP_MAX;
        end
    end

    assign surrogate = (cp >= CP_SURR_LO) && (cp <= CP_SURR_HI);

    // pick the outcome for this position
    always_comb begin
        o_form.incomplete = 1'b0;
        o_form.cp         = CP_REPLACEMENT;
        o_form.adv        = 3'd1;
        if (!b0[7]) begin
            o_form.cp = {13'd0, b0};
        end else if (!(lead2 || lead3 || lead4)) begin
            o_form.cp = CP_REPLACEMENT;
        end else if (len > i_avail) begin
            // cut short: wait for more bytes, or give U+FFFD for the rest at end of text
            o_form.incomplete = !i_eot;
            o_form.adv        = i_avail;
        end else if (!cont_ok || overlong || surrogate || too_big) begin
            o_form.cp = CP_REPLACEMENT;
        end else begin
            o_form.cp  = cp;
            o_form.adv = len;
        end
    end

endmodule

>>> bench/tb_utf8_decoder_with_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_decoder_with_replacement
// Self-checking bench for the UTF-8 decoder. It streams directed corner cases,
// then random texts that are mostly well formed. Random idles sit on both
// sides. A behavioral decoder predicts every code point beat, and the bench
// compares each output beat field by field in order.
// ----------------------------------------------------------------------------
module tb_utf8_decoder_with_replacement;
    import utf8d_pkg::*;

    localparam int unsigned RANDOM_BEATS = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eot;
    } t_text_beat;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } t_cp_beat;

    // Kinds of characters the random texts are built from
    typedef enum int {
        CH_ASCII,
        CH_TWO,
        CH_THREE,
        CH_FOUR,
        CH_SURROGATE,
        CH_JUNK_FORM,
        CH_CUT,
        CH_STRAY_CONT,
        CH_NOISE,
        CH_BAD_LEAD
    } t_char_kind;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic [BYTE_W-1:0] byte_data  = '0;
    logic              byte_eot   = 1'b0;
    logic              byte_valid = 1'b0;
    logic              cp_ready   = 1'b0;

    t_text_beat text_bytes [$];
    t_cp_beat   cp_expected [$];

    // Predictor state: bytes of a form still incomplete
    logic [BYTE_W-1:0] open_form [3];
    int                open_form_n = 0;

    int  total_beats = 0;
    int  beats_taken = 0;
    int  mismatches  = 0;
    int  send_gap    = 0;
    int  recv_stall  = 0;
    bit  send_calm   = 1'b0;
    bit  recv_calm   = 1'b0;
    t_text_beat next_beat;

    utf8d_in_if  text_in ();
    utf8d_out_if cp_out ();

    assign text_in.valid       = byte_valid;
    assign text_in.input_byte  = byte_data;
    assign text_in.end_of_text = byte_eot;
    assign cp_out.ready        = cp_ready;

    utf8_decoder_with_replacement DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_in),
        .o_out   (cp_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length for one beat; calm stretches never idle
    function automatic int idle_draw(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Decode one text byte against the open form and queue the code points
    task automatic decode_text_byte(input logic [BYTE_W-1:0] in_byte, input logic eot);
        logic [BYTE_W-1:0] seq [4];
        logic [CP_W-1:0]   cps [4];
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] lead;
        logic              ok;
        logic              bad;
        logic              cut;
        int                cps_n;
        int                n;
        int                pos;
        int                form_len;
        int                k;
        t_cp_beat          res;

        cps_n = 0;
        cut   = 1'b0;
        pos   = 0;
        n     = open_form_n;
        for (k = 0; k < n; k++) seq[k] = open_form[k];
        seq[n] = in_byte;
        n++;

        while (pos < n && !cut) begin
            lead     = seq[pos];
            form_len = 0;
            cp       = '0;
            if (!lead[7]) begin
                cps[cps_n] = CP_W'(lead);
                cps_n++;
                pos++;
            end else begin
                if ((lead & MASK_LEAD2) == CODE_LEAD2) begin
                    form_len = 2;
                    cp = CP_W'(lead & ~MASK_LEAD2);
                end else if ((lead & MASK_LEAD3) == CODE_LEAD3) begin
                    form_len = 3;
                    cp = CP_W'(lead & ~MASK_LEAD3);
                end else if ((lead & MASK_LEAD4) == CODE_LEAD4) begin
                    form_len = 4;
                    cp = CP_W'(lead & ~MASK_LEAD4);
                end

                if (form_len == 0) begin
                    // invalid lead or stray continuation
                    cps[cps_n] = CP_REPLACEMENT;
                    cps_n++;
                    pos++;
                end else if (pos + form_len > n) begin
                    // form not complete yet: one replacement at end of text
                    if (eot) begin
                        cps[cps_n] = CP_REPLACEMENT;
                        cps_n++;
                        pos = n;
                    end
                    cut = 1'b1;
                end else begin
                    ok = 1'b1;
                    for (k = 1; k < form_len; k++) begin
                        if (ok && ((seq[pos+k] & MASK_CONT) != CODE_CONT))
                            ok = 1'b0;
                        else if (ok)
                            cp = (cp << 6) | CP_W'(seq[pos+k] & ~MASK_CONT);
                    end
                    bad = !ok ||
                          (form_len == 2 && cp < CP_MIN_2) ||
                          (form_len == 3 && cp < CP_MIN_3) ||
                          (form_len == 4 && (cp < CP_MIN_4 || cp > CP_MAX)) ||
                          (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
                    if (bad) begin
                        // replace the lead, rescan from the byte after it
                        cps[cps_n] = CP_REPLACEMENT;
                        cps_n++;
                        pos++;
                    end else begin
                        cps[cps_n] = cp;
                        cps_n++;
                        pos += form_len;
                    end
                end
            end
        end

        // Hold what is left of an open form, clear at end of text
        if (eot || pos >= n) begin
            open_form_n = 0;
        end else begin
            open_form_n = n - pos;
            for (k = 0; k < open_form_n; k++) open_form[k] = seq[pos+k];
        end

        for (k = 0; k < cps_n; k++) begin
            res.cp   = cps[k];
            res.last = (k == cps_n - 1);
            cp_expected.insert(cp_expected.size(), res);
        end
    endtask

    task automatic note_mismatch(input string what, input t_cp_beat exp_beat,
                                 input t_cp_beat act_beat);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s: expected cp %06h last %0b, got cp %06h last %0b",
                     $time, what, exp_beat.cp, exp_beat.last, act_beat.cp, act_beat.last);
        mismatches++;
    endtask

    // Compare one output beat with the oldest expected code point
    task automatic check_code_point(input logic [CP_W-1:0] cp, input logic last);
        t_cp_beat act_beat;
        t_cp_beat exp_beat;

        act_beat.cp   = cp;
        act_beat.last = last;
        if (cp_expected.size() == 0) begin
            exp_beat = '0;
            note_mismatch("unexpected beat", exp_beat, act_beat);
        end else begin
            exp_beat = cp_expected.pop_front();
            if (exp_beat.cp !== act_beat.cp || exp_beat.last !== act_beat.last)
                note_mismatch("wrong beat", exp_beat, act_beat);
        end
    endtask

    task automatic push_beat(input logic [BYTE_W-1:0] data, input logic eot);
        t_text_beat b;
        b.data = data;
        b.eot  = eot;
        text_bytes.insert(text_bytes.size(), b);
    endtask

    // Append one random character, well formed or broken
    task automatic add_char();
        logic [BYTE_W-1:0] seq [$];
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] lead;
        t_char_kind        kind;
        int                pick;
        int                len;
        int                k;
        int                drop;

        pick = $urandom_range(0, 19);
        if (pick < 6)       kind = CH_ASCII;
        else if (pick < 9)  kind = CH_TWO;
        else if (pick < 12) kind = CH_THREE;
        else if (pick < 14) kind = CH_FOUR;
        else if (pick < 15) kind = CH_SURROGATE;
        else if (pick < 16) kind = CH_JUNK_FORM;
        else if (pick < 17) kind = CH_CUT;
        else if (pick < 18) kind = CH_STRAY_CONT;
        else if (pick < 19) kind = CH_NOISE;
        else                kind = CH_BAD_LEAD;

        len = 0;
        cp  = '0;
        case (kind)
            CH_ASCII:      seq.insert(seq.size(), BYTE_W'($urandom_range(0, 8'h7F)));
            CH_TWO: begin
                cp  = CP_W'($urandom_range(CP_MIN_2, CP_MIN_3 - 1));
                len = 2;
            end
            CH_THREE: begin
                cp  = CP_W'($urandom_range(CP_MIN_3, CP_MIN_4 - 1));
                len = 3;
            end
            CH_FOUR: begin
                cp  = CP_W'($urandom_range(CP_MIN_4, CP_MAX));
                len = 4;
            end
            CH_SURROGATE: begin
                cp  = CP_W'($urandom_range(CP_SURR_LO, CP_SURR_HI));
                len = 3;
            end
            CH_CUT: begin
                len = $urandom_range(2, 4);
                if (len == 2)      cp = CP_W'($urandom_range(CP_MIN_2, CP_MIN_3 - 1));
                else if (len == 3) cp = CP_W'($urandom_range(CP_MIN_3, CP_MIN_4 - 1));
                else               cp = CP_W'($urandom_range(CP_MIN_4, CP_MAX));
            end
            CH_JUNK_FORM: begin
                // any lead with continuations: can give overlong and out of range forms
                lead = BYTE_W'($urandom_range(8'hC0, 8'hF7));
                seq.insert(seq.size(), lead);
                k = ((lead & MASK_LEAD2) == CODE_LEAD2) ? 1 :
                    ((lead & MASK_LEAD3) == CODE_LEAD3) ? 2 : 3;
                repeat (k) seq.insert(seq.size(), BYTE_W'($urandom_range(8'h80, 8'hBF)));
            end
            CH_STRAY_CONT: seq.insert(seq.size(), BYTE_W'($urandom_range(8'h80, 8'hBF)));
            CH_NOISE:      seq.insert(seq.size(), BYTE_W'($urandom_range(0, 8'hFF)));
            default:       seq.insert(seq.size(), BYTE_W'($urandom_range(8'hF8, 8'hFF)));
        endcase

        // Encode the code point in its shortest form
        if (len != 0) begin
            case (len)
                2:       seq.insert(seq.size(), {3'b110, cp[10:6]});
                3:       seq.insert(seq.size(), {4'b1110, cp[15:12]});
                default: seq.insert(seq.size(), {5'b11110, cp[20:18]});
            endcase
            for (k = len - 2; k >= 0; k--) seq.insert(seq.size(), {2'b10, cp[6*k +: 6]});
        end

        // Chop the tail of a cut form
        if (kind == CH_CUT) begin
            drop = $urandom_range(1, len - 1);
            repeat (drop) void'(seq.pop_back());
        end

        foreach (seq[i]) push_beat(seq[i], 1'b0);
    endtask

    // Append one random text, sometimes closed by the end-of-text flag
    task automatic add_text();
        t_text_beat b;
        int         chars;

        chars = $urandom_range(1, 10);
        repeat (chars) add_char();
        if ($urandom_range(0, 1) == 1) begin
            b = text_bytes.pop_back();
            b.eot = 1'b1;
            text_bytes.insert(text_bytes.size(), b);
        end
        // occasional noise with a random flag between texts
        if ($urandom_range(0, 7) == 0)
            push_beat(BYTE_W'($urandom_range(0, 8'hFF)), 1'(($urandom_range(0, 1))));
    endtask

    // Driver: present queued bytes with random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_valid <= 1'b0;
            send_gap = idle_draw(send_calm);
        end else begin
            if (byte_valid && text_in.ready) begin
                decode_text_byte(byte_data, byte_eot);
                beats_taken++;
            end
            if (!byte_valid || text_in.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end else if (text_bytes.size() > 0) begin
                    next_beat = text_bytes.pop_front();
                    byte_data  <= next_beat.data;
                    byte_eot   <= next_beat.eot;
                    byte_valid <= 1'b1;
                    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                    send_gap = idle_draw(send_calm);
                end else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each code point beat, then stall for a random while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (cp_out.valid && cp_ready) begin
                check_code_point(cp_out.code_point, cp_out.last_of_run);
                if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
                recv_stall = idle_draw(recv_calm);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                cp_ready <= 1'b0;
            end else begin
                cp_ready <= 1'b1;
            end
        end
    end

    initial begin
        // Plain ASCII at both ends of the range
        push_beat(8'h00, 1'b0);
        push_beat(8'h7F, 1'b1);
        // Shortest two-byte form
        push_beat(8'hC2, 1'b0);
        push_beat(8'h80, 1'b0);
        // Shortest three-byte form
        push_beat(8'hE0, 1'b0);
        push_beat(8'hA0, 1'b0);
        push_beat(8'h80, 1'b0);
        // Highest code point
        push_beat(8'hF4, 1'b0);
        push_beat(8'h8F, 1'b0);
        push_beat(8'hBF, 1'b0);
        push_beat(8'hBF, 1'b0);
        // Overlong two-byte form
        push_beat(8'hC0, 1'b0);
        push_beat(8'h80, 1'b0);
        // Surrogate
        push_beat(8'hED, 1'b0);
        push_beat(8'hA0, 1'b0);
        push_beat(8'h80, 1'b0);
        // Above the highest code point
        push_beat(8'hF4, 1'b0);
        push_beat(8'h90, 1'b0);
        push_beat(8'h80, 1'b0);
        push_beat(8'h80, 1'b0);
        // Stray continuation, then an invalid lead
        push_beat(8'h80, 1'b0);
        push_beat(8'hFF, 1'b0);
        // Bad continuation: one replacement, then three rescanned bytes
        push_beat(8'hF0, 1'b0);
        push_beat(8'h41, 1'b0);
        push_beat(8'h42, 1'b0);
        push_beat(8'h43, 1'b0);
        // Form cut by the end of text
        push_beat(8'hE2, 1'b0);
        push_beat(8'h82, 1'b1);

        total_beats = text_bytes.size() + RANDOM_BEATS;
        while (text_bytes.size() < total_beats) add_text();
        total_beats = text_bytes.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to go in and every code point to come out
        while (beats_taken < total_beats) @(posedge i_clk);
        while (cp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_utf8_decoder_with_replacement passed");
        end else begin
            $display("tb_utf8_decoder_with_replacement failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb_utf8_decoder_with_replacement failed");
        $finish;
    end

endmodule
